// ----- rtl/core/kcd_pkg.sv -----
// Shared types and constants for the key capture double buffer.
// No dependencies; every other file in rtl/core except kcd_ram imports this package.
package kcd_pkg;

  localparam int KEY_W       = 8;
  localparam int MIN_READ_W  = 7;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int JOB_CNT_W   = 8;   // holds any bank size up to 255
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;
  localparam int PEND_W      = 2;   // queue entries plus the one being drained

  localparam logic [7:0] NEVER_CS       = 8'd255;
  localparam logic [7:0] POLL_PERIOD_RST = 8'd5;

  typedef enum logic {
    FUNC_POLL = 1'b0,
    FUNC_READ = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_OVERRUN = 2'd2
  } result_kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MIN_READ    = 2'd0,
    REG_END_CHAR    = 2'd1,
    REG_TIMEOUT     = 2'd2,
    REG_POLL_PERIOD = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    B_IDLE = 1'b0,
    B_RUN  = 1'b1
  } back_state_t;

  typedef struct packed {
    func_t            func;
    logic [KEY_W-1:0] key_byte;
  } key_cmd_t;

  typedef struct packed {
    result_kind_t     kind;
    logic [KEY_W-1:0] data_byte;
    logic             last;
  } key_result_t;

  // One finished read, handed from front to back.
  typedef struct packed {
    result_kind_t         kind;
    logic                 bank;
    logic [JOB_CNT_W-1:0] count;
  } job_t;

  // Back end tells the front a bank is no longer being read.
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

endpackage

// ----- rtl/core/kcd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/kcd_queue.sv -----
// Two-entry job queue between capture front and output back end.
// Depends on kcd_pkg.
module kcd_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  kcd_pkg::job_t push_job,
  input  logic         pop,
  output kcd_pkg::job_t head,
  output logic         empty,
  output logic         full
);
  import kcd_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;

  assign head  = entries[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == QCNT_W'(QUEUE_DEPTH));

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// ----- rtl/core/kcd_front.sv -----
// Capture front end: config registers, key store writes, count, timer,
// pending read and completion decisions. Depends on kcd_pkg.
module kcd_front #(
  parameter int BANK_BYTES = 64,
  localparam int IW = (BANK_BYTES > 1) ? $clog2(BANK_BYTES) : 1,
  localparam int AW = IW + 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  kcd_pkg::key_cmd_t                 cmd,
  output logic                              busy,
  input  logic                              cfg_we,
  input  logic [kcd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [kcd_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              ram_we,
  output logic [AW-1:0]                     ram_waddr,
  output logic [kcd_pkg::KEY_W-1:0]         ram_wdata,
  output logic                              push,
  output kcd_pkg::job_t                     push_job,
  input  logic                              q_full,
  input  kcd_pkg::release_t                 rel
);
  import kcd_pkg::*;

  localparam int CW    = $clog2(BANK_BYTES + 2);
  localparam int CMP_W = (CW > MIN_READ_W) ? CW : MIN_READ_W;
  localparam logic [CW-1:0] BANK_CNT = CW'(BANK_BYTES);

  // config
  logic [MIN_READ_W-1:0] min_read;
  logic [7:0]            end_char;
  logic [7:0]            read_timeout;
  logic [7:0]            poll_period_cs;

  // capture state
  logic              bank_sel, bank_sel_next;
  logic [CW-1:0]     cnt, cnt_next;
  logic              pending, pending_next;
  logic [7:0]        time_left, time_left_next;
  logic [KEY_W-1:0]  last_key, last_key_next;
  logic [PEND_W-1:0] pend_cnt [2];
  logic [PEND_W-1:0] pend_cnt_next [2];

  logic          accept;
  logic          do_complete;
  logic          do_overrun;
  logic [CW-1:0] cnt_c;

  function automatic logic is_ready(input logic [CW-1:0] c, input logic [7:0] t,
                                    input logic [KEY_W-1:0] lk,
                                    input logic [MIN_READ_W-1:0] mr,
                                    input logic [7:0] ec);
    logic hit;
    hit = (CMP_W'(c) >= CMP_W'(mr)) || (t == 8'd0);
    if (ec != 8'd0 && c != '0 && lk == ec) begin
      hit = 1'b1;
    end
    return hit;
  endfunction

  // hold off while the queue is full or a run from the bank we would fill is still queued or being read
  assign busy   = q_full || (pend_cnt[bank_sel] != '0);
  assign accept = start && !busy;

  always_comb begin
    cnt_next       = cnt;
    time_left_next = time_left;
    bank_sel_next  = bank_sel;
    pending_next   = pending;
    last_key_next  = last_key;
    ram_we         = 1'b0;
    ram_waddr      = {bank_sel, cnt[IW-1:0]};
    ram_wdata      = cmd.key_byte;
    do_complete    = 1'b0;
    do_overrun     = 1'b0;
    cnt_c          = cnt;
    push           = 1'b0;
    push_job.kind  = KIND_EMPTY;
    push_job.bank  = bank_sel;
    push_job.count = '0;

    if (accept) begin
      if (cmd.func == FUNC_POLL) begin
        if (cmd.key_byte != '0) begin
          if (cnt < BANK_CNT) begin
            ram_we        = 1'b1;
            last_key_next = cmd.key_byte;
          end
          if (cnt <= BANK_CNT) begin
            cnt_next = cnt + 1'b1;
          end
        end
        if (time_left != NEVER_CS) begin
          time_left_next = (time_left > poll_period_cs) ? time_left - poll_period_cs : 8'd0;
        end
        cnt_c       = cnt_next;
        do_complete = pending && is_ready(cnt_next, time_left_next, last_key_next,
                                          min_read, end_char);
      end else if (!pending) begin
        if (cnt > BANK_CNT) begin
          do_overrun = 1'b1;
        end else begin
          time_left_next = read_timeout;
          if (is_ready(cnt, read_timeout, last_key, min_read, end_char)) begin
            do_complete = 1'b1;
          end else begin
            pending_next = 1'b1;
          end
        end
      end
    end

    if (do_complete) begin
      if (cnt_c > BANK_CNT) begin
        do_overrun = 1'b1;
      end else begin
        push           = 1'b1;
        push_job.kind  = (cnt_c == '0) ? KIND_EMPTY : KIND_DATA;
        push_job.bank  = bank_sel;
        push_job.count = JOB_CNT_W'(cnt_c);
        bank_sel_next  = ~bank_sel;
        cnt_next       = '0;
        time_left_next = read_timeout;
        pending_next   = 1'b0;
      end
    end

    if (do_overrun) begin
      push           = 1'b1;
      push_job.kind  = KIND_OVERRUN;
      push_job.count = '0;
      bank_sel_next  = 1'b0;
      cnt_next       = '0;
      time_left_next = 8'd0;
      pending_next   = 1'b0;
    end
  end

  // outstanding data runs per bank
  always_comb begin
    for (int b = 0; b < 2; b++) begin
      pend_cnt_next[b] = pend_cnt[b];
      if (push && push_job.kind == KIND_DATA && push_job.bank == b[0]) begin
        pend_cnt_next[b] = pend_cnt_next[b] + 1'b1;
      end
      if (rel.valid && rel.bank == b[0]) begin
        pend_cnt_next[b] = pend_cnt_next[b] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_read       <= '0;
      end_char       <= '0;
      read_timeout   <= '0;
      poll_period_cs <= POLL_PERIOD_RST;
      bank_sel       <= 1'b0;
      cnt            <= '0;
      pending        <= 1'b0;
      time_left      <= '0;
      pend_cnt[0]    <= '0;
      pend_cnt[1]    <= '0;
    end else begin
      bank_sel    <= bank_sel_next;
      cnt         <= cnt_next;
      pending     <= pending_next;
      time_left   <= time_left_next;
      pend_cnt[0] <= pend_cnt_next[0];
      pend_cnt[1] <= pend_cnt_next[1];
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_MIN_READ:    min_read       <= cfg_data[MIN_READ_W-1:0];
          REG_END_CHAR:    end_char       <= cfg_data;
          REG_TIMEOUT:     read_timeout   <= cfg_data;
          REG_POLL_PERIOD: poll_period_cs <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    last_key <= last_key_next;
  end

endmodule

// ----- rtl/core/kcd_back.sv -----
// Output back end: pops jobs, reads the finished bank one byte a cycle and
// drives the result beats. Depends on kcd_pkg.
module kcd_back #(
  parameter int BANK_BYTES = 64,
  localparam int IW = (BANK_BYTES > 1) ? $clog2(BANK_BYTES) : 1,
  localparam int AW = IW + 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_empty,
  input  kcd_pkg::job_t             head,
  output logic                      pop,
  output logic                      reading,
  output logic [AW-1:0]             ram_raddr,
  input  logic [kcd_pkg::KEY_W-1:0] ram_rdata,
  output kcd_pkg::release_t         rel,
  output logic                      strobe,
  output kcd_pkg::key_result_t      result
);
  import kcd_pkg::*;

  back_state_t          state, state_next;
  logic                 cur_bank;
  logic [JOB_CNT_W-1:0] cur_count;
  logic [IW-1:0]        idx;
  logic                 last_issue;
  logic                 s1_valid;
  result_kind_t         s1_kind;
  logic                 s1_last;

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!q_empty && head.kind == KIND_DATA) begin
          state_next = B_RUN;
        end
      end
      B_RUN: begin
        if (last_issue) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop        = (state == B_IDLE) && !q_empty;
    reading    = (state == B_RUN);
    ram_raddr  = {cur_bank, idx};
    last_issue = (JOB_CNT_W'(idx) + 1'b1) == cur_count;
    rel.valid  = reading && last_issue;
    rel.bank   = cur_bank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      s1_valid <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= reading || (pop && head.kind != KIND_DATA);
    end
  end

  always_ff @(posedge clk) begin
    s1_kind <= reading ? KIND_DATA : head.kind;
    s1_last <= reading ? last_issue : 1'b1;
    if (pop) begin
      cur_bank  <= head.bank;
      cur_count <= head.count;
      idx       <= '0;
    end else if (reading) begin
      idx <= idx + 1'b1;
    end
  end

  assign strobe           = s1_valid;
  assign result.kind      = s1_kind;
  assign result.data_byte = (s1_kind == KIND_DATA) ? ram_rdata : '0;
  assign result.last      = s1_last;

endmodule

// ----- rtl/core/key_capture_double_buffer.sv -----
// Top level of the double-buffered key capture block.
// Depends on kcd_pkg, kcd_front, kcd_queue, kcd_back and kcd_ram.
//
// Usage:
//   Command channel: drive cmd and raise start; the beat is taken at a rising
//   edge with start high and busy low. cmd.func = poll tick (key_byte, 0 for
//   no key) or read request.
//   Result channel: strobe marks a result beat for exactly one cycle; the
//   receiver cannot stall it. A run of data beats ends with last set; empty
//   and overrun status beats come alone with last set.
//   Config port: cfg_we/cfg_index/cfg_data write min_read, end_char,
//   read_timeout, poll_period_cs; write only while idle.
// Timing:
//   The front takes one command per cycle while busy is low. A completing read
//   queues a job; with the back end idle, the back end pops it and a status
//   beat comes out of the result register, while a data run first enters
//   the run state and then gives one byte per cycle from the registered RAM
//   read, set by the single RAM read port. busy rises while the two-entry
//   job queue is full or a run from the bank that would be filled is still
//   queued or being read out.
// Reset: synchronous, clears counters, bank select, pending read, timer, job
//   queue and config (poll period back to 5). The key RAM is not cleared.
module key_capture_double_buffer #(
  parameter int BANK_BYTES = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  kcd_pkg::key_cmd_t               cmd,
  output logic                            strobe,
  output kcd_pkg::key_result_t            result,
  input  logic                            cfg_we,
  input  logic [kcd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kcd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import kcd_pkg::*;

  localparam int IW = (BANK_BYTES > 1) ? $clog2(BANK_BYTES) : 1;
  localparam int AW = IW + 1;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [AW-1:0]    ram_raddr;
  logic [KEY_W-1:0] ram_wdata;
  logic [KEY_W-1:0] ram_rdata;
  logic             push;
  job_t             push_job;
  logic             pop;
  job_t             head;
  logic             q_empty;
  logic             q_full;
  logic             back_reading;
  release_t         rel;

  // front: classifies commands, owns all capture state
  kcd_front #(.BANK_BYTES(BANK_BYTES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .push      (push),
    .push_job  (push_job),
    .q_full    (q_full),
    .rel       (rel)
  );

  // finished reads wait here in order
  kcd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // both banks in one RAM: bank select is the address MSB
  kcd_ram #(.WIDTH(KEY_W), .DEPTH(2 ** AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // back: drains jobs into result beats
  kcd_back #(.BANK_BYTES(BANK_BYTES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .reading   (back_reading),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .rel       (rel),
    .strobe    (strobe),
    .result    (result)
  );

  // status beats stand alone
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    strobe && result.kind != KIND_DATA |-> result.last)
    else $error("status beat without last");

  // a data run is never broken up
  a_run_contig: assert property (@(posedge clk) disable iff (rst)
    strobe && result.kind == KIND_DATA && !result.last |=>
    strobe && result.kind == KIND_DATA)
    else $error("data run interrupted");

  // capture never writes the bank being read out
  a_bank_split: assert property (@(posedge clk) disable iff (rst)
    ram_we && back_reading |-> ram_waddr[AW-1] != ram_raddr[AW-1])
    else $error("write into bank under readout");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !strobe)
    else $error("result beat right after reset");

endmodule

// ----- sim/tb_key_capture_double_buffer.sv -----
// Self-checking bench for key_capture_double_buffer: directed and random key
// traffic, predicted beat by beat and compared in order. Needs kcd_pkg and RTL.
module tb_key_capture_double_buffer;
  import kcd_pkg::*;

  localparam int BANK           = 64;
  localparam int RANDOM_ITEMS   = 275;
  localparam int WATCHDOG_LIMIT = 1000;  // idle cycles
  localparam int SETTLE_CYCLES  = 16;    // lets a no-result command clear the front
  localparam int DRAIN_CYCLES   = 80;    // one full-bank run plus pipeline
  localparam int MAX_PRINTED    = 100;
  localparam int QUEUE_AHEAD    = 8;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  key_cmd_t               cmd = '0;
  logic                   strobe;
  key_result_t            result;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Shadow of the capture banks and read state.
  logic [7:0]  key_ram [0:2*BANK-1];
  logic        bank_sel;
  int unsigned fill_count;    // goes to BANK+1 on overrun
  logic        read_waiting;
  logic [7:0]  time_left;     // NEVER_CS means no countdown

  // Shadow of the config registers.
  logic [6:0]  min_read_r;
  logic [7:0]  end_char_r;
  logic [7:0]  timeout_r;
  logic [7:0]  poll_r;

  key_result_t due_beats [$];   // result beats owed by the block, oldest first
  key_cmd_t    cmd_queue [$];   // commands waiting for the driver

  int err_count   = 0;
  int gap_left    = 0;
  int idle_cycles = 0;
  bit steady      = 1'b0;       // no sender gaps in this phase

  key_capture_double_buffer #(.BANK_BYTES(BANK)) DUT (
    .clk, .rst, .start, .busy, .cmd, .strobe, .result, .cfg_we, .cfg_index, .cfg_data
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic note_mismatch(string what);
    if (err_count < MAX_PRINTED) $display("tb: mismatch at %0t: %s", $time, what);
    err_count++;
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic void owe(result_kind_t k, logic [7:0] d, logic l);
    key_result_t r;
    r.kind      = k;
    r.data_byte = d;
    r.last      = l;
    due_beats.push_back(r);
  endfunction

  function automatic void clear_capture();
    bank_sel     = 1'b0;
    fill_count   = 0;
    read_waiting = 1'b0;
    time_left    = 8'd0;
  endfunction

  // Overrun: lone error beat, buffer state wiped, registers kept.
  function automatic void flag_overrun();
    clear_capture();
    owe(KIND_OVERRUN, 8'd0, 1'b1);
  endfunction

  function automatic bit read_ready();
    int n;
    if (fill_count >= min_read_r) return 1'b1;
    if (time_left == 8'd0) return 1'b1;
    if (end_char_r == 8'd0 || fill_count == 0) return 1'b0;
    n = (fill_count > BANK) ? BANK : fill_count;
    return key_ram[int'(bank_sel) * BANK + n - 1] == end_char_r;
  endfunction

  function automatic void complete_read();
    int base;
    base = int'(bank_sel) * BANK;
    if (fill_count > BANK) begin
      flag_overrun();
      return;
    end
    if (fill_count == 0) owe(KIND_EMPTY, 8'd0, 1'b1);
    else
      for (int i = 0; i < fill_count; i++)
        owe(KIND_DATA, key_ram[base + i], (i + 1) == fill_count);
    // flip banks, restart the timeout
    bank_sel     = ~bank_sel;
    fill_count   = 0;
    time_left    = timeout_r;
    read_waiting = 1'b0;
  endfunction

  function automatic void track_cmd(key_cmd_t c);
    if (c.func == FUNC_POLL) begin
      if (c.key_byte != 8'd0) begin
        if (fill_count < BANK) key_ram[int'(bank_sel) * BANK + fill_count] = c.key_byte;
        if (fill_count <= BANK) fill_count++;
      end
      // countdown saturates at zero; a zero period never moves it
      if (time_left != NEVER_CS) begin
        if (time_left > poll_r) time_left = time_left - poll_r;
        else time_left = 8'd0;
      end
      if (read_waiting && read_ready()) complete_read();
    end else if (!read_waiting) begin
      // a read while one is pending is dropped
      if (fill_count > BANK) flag_overrun();
      else begin
        time_left = timeout_r;
        if (read_ready()) complete_read();
        else read_waiting = 1'b1;
      end
    end
  endfunction

  // ---------------------------------------------------------------- driver

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One command beat at a time. start is settled once per edge so a
  // back-to-back beat keeps it high without a low/high pair in one step.
  always @(posedge clk) begin : drive
    logic next_start;
    next_start = start;
    if (rst) begin
      next_start = 1'b0;
      gap_left   = 0;
    end else begin
      if (start && !busy) begin
        track_cmd(cmd);
        next_start = 1'b0;
      end
      if (!next_start) begin
        if (gap_left > 0) gap_left--;
        else if (cmd_queue.size() != 0) begin
          cmd        <= cmd_queue.pop_front();
          next_start = 1'b1;
          gap_left   = pick_gap();
        end
      end
    end
    start <= next_start;
  end

  // ---------------------------------------------------------------- monitor

  // Result beats cannot be stalled: every strobe is taken at the edge.
  // The watchdog also lives here; any beat on either side resets it.
  always @(posedge clk) begin : watch
    key_result_t want;
    if (!rst) begin
      if (strobe) begin
        if (due_beats.size() == 0) note_mismatch("result beat with nothing expected");
        else begin
          want = due_beats.pop_front();
          if (result.kind !== want.kind)
            note_mismatch($sformatf("kind %0d, expected %0d", result.kind, want.kind));
          if (result.data_byte !== want.data_byte)
            note_mismatch($sformatf("data_byte %02h, expected %02h",
                                    result.data_byte, want.data_byte));
          if (result.last !== want.last)
            note_mismatch($sformatf("last %0b, expected %0b", result.last, want.last));
        end
      end
      if (strobe || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send(func_t f, logic [7:0] k);
    key_cmd_t c;
    c.func     = f;
    c.key_byte = k;
    while (cmd_queue.size() >= QUEUE_AHEAD) @(negedge clk);
    cmd_queue.push_back(c);
  endtask

  // Wait until every command is taken and every owed beat has shown up,
  // then give the front a few cycles for commands that owe nothing.
  // Checked on the falling edge, after the driver's updates have landed.
  task automatic settle();
    while (cmd_queue.size() != 0 || start || due_beats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only from settle points, so the shadow copy can
  // be updated right away.
  task automatic write_reg(cfg_reg_t idx, logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_MIN_READ:    min_read_r = val[6:0];   // top bit of the data is dropped
      REG_END_CHAR:    end_char_r = val;
      REG_TIMEOUT:     timeout_r  = val;
      REG_POLL_PERIOD: poll_r     = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [7:0] mr, logic [7:0] ec, logic [7:0] tm, logic [7:0] pp);
    write_reg(REG_MIN_READ, mr);
    write_reg(REG_END_CHAR, ec);
    write_reg(REG_TIMEOUT, tm);
    write_reg(REG_POLL_PERIOD, pp);
  endtask

  task automatic random_config();
    logic [6:0] mr;
    logic       top;
    logic [7:0] ec;
    logic [7:0] tm;
    logic [7:0] pp;
    case ($urandom_range(0, 5))
      0: mr = 7'd0;
      1: mr = 7'd1;
      2: mr = 7'd64;
      3: mr = 7'd65;
      4: mr = 7'($urandom_range(0, 127));
      default: mr = 7'($urandom_range(2, 12));
    endcase
    top = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: ec = 8'd0;
      1: ec = 8'hFF;
      default: ec = 8'($urandom_range(1, 255));
    endcase
    case ($urandom_range(0, 4))
      0: tm = 8'd0;
      1: tm = NEVER_CS;
      2: tm = 8'd254;
      default: tm = 8'($urandom_range(1, 60));
    endcase
    case ($urandom_range(0, 5))
      0: pp = 8'd0;
      1: pp = 8'd1;
      2: pp = 8'hFF;
      3: pp = POLL_PERIOD_RST;
      default: pp = 8'($urandom_range(1, 255));
    endcase
    set_config({top, mr}, ec, tm, pp);
  endtask

  // Key bytes for a well-formed read: some empty ticks, some end characters.
  function automatic logic [7:0] rand_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'd0;
    if (r < 30) return end_char_r;
    return 8'($urandom_range(1, 255));
  endfunction

  initial begin
    int sent;
    int phase_items;
    int pick;
    int len;
    clear_capture();
    min_read_r = 7'd0;
    end_char_r = 8'd0;
    timeout_r  = 8'd0;
    poll_r     = POLL_PERIOD_RST;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset config: every read completes at once.
    send(FUNC_READ, 8'd0);          // nothing stored: empty status
    send(FUNC_POLL, 8'hFF);
    send(FUNC_POLL, 8'h00);         // no key, only a tick
    send(FUNC_POLL, 8'h01);
    send(FUNC_READ, 8'hFF);         // run FF, 01
    settle();

    // Count of 3 or carriage return ends a read, no timeout.
    set_config(8'd3, 8'h0D, NEVER_CS, POLL_PERIOD_RST);
    send(FUNC_READ, 8'd0);          // goes pending
    send(FUNC_READ, 8'd0);          // dropped while pending
    send(FUNC_POLL, 8'h41);
    send(FUNC_POLL, 8'h00);
    send(FUNC_POLL, 8'h0D);         // end character completes
    send(FUNC_READ, 8'd0);
    send(FUNC_POLL, 8'h01);
    send(FUNC_POLL, 8'h02);
    send(FUNC_POLL, 8'h03);         // count completes
    settle();

    // Zero poll period: the timer stands still, the read stays pending.
    set_config(8'd64, 8'd0, 8'd20, 8'd0);
    send(FUNC_READ, 8'd0);
    send(FUNC_POLL, 8'h55);
    send(FUNC_POLL, 8'h66);
    settle();
    write_reg(REG_POLL_PERIOD, 8'd10);
    send(FUNC_POLL, 8'h00);
    send(FUNC_POLL, 8'h00);         // timeout expires, run 55, 66
    settle();
    write_reg(REG_TIMEOUT, 8'd0);
    send(FUNC_READ, 8'd0);          // zero timeout: done at once
    settle();

    // Overrun both ways: a pending read that completes past a full bank,
    // then a fresh read that finds one.
    set_config(8'd65, 8'd0, NEVER_CS, 8'd1);
    send(FUNC_READ, 8'd0);
    repeat (BANK + 1) send(FUNC_POLL, 8'($urandom_range(1, 255)));
    repeat (BANK + 2) send(FUNC_POLL, 8'($urandom_range(1, 255)));
    send(FUNC_READ, 8'd0);
    settle();

    // Random phases: mostly a read followed by ticks, some full-bank bursts,
    // some raw noise.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      random_config();
      steady      = ($urandom_range(0, 3) == 0);
      phase_items = 0;
      while (phase_items < 45 && sent < RANDOM_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 70) : $urandom_range(0, 10);
          send(FUNC_READ, 8'($urandom_range(0, 255)));
          repeat (len) send(FUNC_POLL, rand_key());
          len++;
        end else if (pick < 77) begin
          len = $urandom_range(BANK - 4, BANK + 3);
          repeat (len) send(FUNC_POLL, 8'($urandom_range(1, 255)));
          send(FUNC_READ, 8'($urandom_range(0, 255)));
          len++;
        end else begin
          len = $urandom_range(1, 4);
          repeat (len) send(func_t'(1'($urandom_range(0, 1))), 8'($urandom_range(0, 255)));
        end
        phase_items += len;
        sent        += len;
        // now and then hold off until the block has caught up
        if ($urandom_range(0, 7) == 0) settle();
      end
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (due_beats.size() != 0)
      note_mismatch($sformatf("%0d result beats never arrived", due_beats.size()));
    if (err_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
